FILE: rtl/assert_macros.svh
// assertion macros used by the port level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent holds, consequent in the same cycle
`define FPFA_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// antecedent holds, consequent in the next cycle
`define FPFA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/fpfa_pkg.sv
// types and constants of the fixed partition fit allocator
package fpfa_pkg;

    localparam int NUM_PARTITIONS = 16;
    localparam int SIZE_BITS      = 16;
    localparam int IDX_W          = (NUM_PARTITIONS > 1) ? $clog2(NUM_PARTITIONS) : 1;
    localparam int CMP_W          = (SIZE_BITS > 16) ? SIZE_BITS : 16;
    localparam int CFG_IDX_W      = 1;
    localparam int CFG_DATA_W     = 5;

    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_ALLOC = 2'd1;

    localparam logic [1:0] POLICY_FIRST = 2'd0;
    localparam logic [1:0] POLICY_BEST  = 2'd1;
    localparam logic [1:0] POLICY_WORST = 2'd2;

    localparam logic [1:0] STATUS_LOADED  = 2'd0;
    localparam logic [1:0] STATUS_GRANTED = 2'd1;
    localparam logic [1:0] STATUS_NO_FIT  = 2'd2;
    localparam logic [1:0] STATUS_QUERY   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_FIT_POLICY    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_IN_USE = 1'b1;

    localparam logic [4:0] BLOCKS_RESET = 5'd16;

    typedef logic [SIZE_BITS-1:0] t_size;
    typedef logic [IDX_W-1:0]     t_pos;

    typedef struct packed {
        logic [1:0]  mode;
        logic [3:0]  block_index;
        logic [15:0] block_size;
        logic [15:0] request_size;
        logic [15:0] process_id;
    } t_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  chosen_block;
        logic        block_taken;
        logic [15:0] owner_id;
        logic [15:0] reported_size;
    } t_result;

    // item travelling down the row of cells
    typedef struct packed {
        logic        valid;
        t_item       item;
        logic [1:0]  policy;
        logic [4:0]  count;
        logic        found;
        t_pos        pick;
        t_size       pick_size;
        logic        rep_taken;
        logic [15:0] rep_owner;
        t_size       rep_size;
    } t_tok;

    // grant written back into the chosen cell
    typedef struct packed {
        logic        valid;
        t_pos        pick;
        logic [15:0] pid;
    } t_commit;

endpackage

FILE: rtl/fixed_partition_fit_allocator.sv
// top level: fixed partition allocator built as a row of partition cells
//
// Usage: present an item on i_item and raise i_start while o_busy is low; the
// item is taken at that clock edge. Mode load writes a partition size and frees
// it, mode allocate searches for a free partition by the configured policy and
// marks it taken, mode query reports one partition.
// Each item is registered at the head, travels down the row of NUM_PARTITIONS
// cells, one cell per clock, and its result is registered at the tail: o_done
// is high for a single cycle with o_result valid. o_busy stays high from the
// accepting edge up to the result beat, so one item is in flight at a time; a
// new one may be started in the cycle the result shows.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx
// (0 fit policy, 1 partitions in use) at once; write only while idle.
// Reset clears all partitions to size 0, free, owner 0, policy first-fit and
// sixteen partitions in use. The result has no back-pressure: the receiver
// must take each beat in the cycle it is shown.
module fixed_partition_fit_allocator (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  fpfa_pkg::t_item                     i_item,
    output logic                                o_busy,
    output logic                                o_done,
    output fpfa_pkg::t_result                   o_result,
    input  logic                                i_cfg_we,
    input  logic [fpfa_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [fpfa_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import fpfa_pkg::*;

    logic [1:0] r_fit_policy;
    logic [4:0] r_blocks_in_use;
    logic       r_busy;
    logic       r_done;
    t_result    r_result, n_result;
    t_tok       r_head, n_head;
    t_tok       tok [0:NUM_PARTITIONS];
    t_commit    commit;
    t_tok       tail;

    assign tok[0] = r_head;
    assign tail   = tok[NUM_PARTITIONS];

    genvar g;
    generate
        for (g = 0; g < NUM_PARTITIONS; g++) begin : g_cell
            fpfa_cell u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_pos    (IDX_W'(g)),
                .i_tok    (tok[g]),
                .i_commit (commit),
                .o_tok    (tok[g+1])
            );
        end
    endgenerate

    always_comb begin
        n_head = '0;
        if (i_start && !r_busy) begin
            n_head.valid  = 1'b1;
            n_head.item   = i_item;
            n_head.policy = r_fit_policy;
            n_head.count  = r_blocks_in_use;
        end
    end

    always_comb begin
        commit.valid = tail.valid && tail.item.mode == MODE_ALLOC && tail.found;
        commit.pick  = tail.pick;
        commit.pid   = tail.item.process_id;

        n_result = '0;
        if (tail.item.mode == MODE_LOAD) begin
            n_result.status        = STATUS_LOADED;
            n_result.chosen_block  = tail.item.block_index;
            n_result.block_taken   = tail.rep_taken;
            n_result.owner_id      = tail.rep_owner;
            n_result.reported_size = 16'(tail.rep_size);
        end else if (tail.item.mode == MODE_ALLOC) begin
            if (tail.found) begin
                n_result.status        = STATUS_GRANTED;
                n_result.chosen_block  = 4'(tail.pick);
                n_result.block_taken   = 1'b1;
                n_result.owner_id      = tail.item.process_id;
                n_result.reported_size = 16'(tail.pick_size);
            end else begin
                n_result.status = STATUS_NO_FIT;
            end
        end else begin
            n_result.status        = STATUS_QUERY;
            n_result.chosen_block  = tail.item.block_index;
            n_result.block_taken   = tail.rep_taken;
            n_result.owner_id      = tail.rep_owner;
            n_result.reported_size = 16'(tail.rep_size);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fit_policy    <= POLICY_FIRST;
            r_blocks_in_use <= BLOCKS_RESET;
            r_busy          <= 1'b0;
            r_done          <= 1'b0;
            r_head          <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_FIT_POLICY:    r_fit_policy    <= i_cfg_data[1:0];
                    CFG_BLOCKS_IN_USE: r_blocks_in_use <= i_cfg_data[4:0];
                    default: ;
                endcase
            end

            r_head <= n_head;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
            end

            r_done <= tail.valid;
            if (tail.valid) begin
                r_busy <= 1'b0;
            end
        end
    end

    // result payload register, qualified by r_done
    always_ff @(posedge i_clk) begin
        if (tail.valid) begin
            r_result <= n_result;
        end
    end

    assign o_busy   = r_busy;
    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

FILE: rtl/fpfa_cell.sv
// one partition entry with its stage of the scan chain
module fpfa_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  fpfa_pkg::t_pos    i_pos,
    input  fpfa_pkg::t_tok    i_tok,
    input  fpfa_pkg::t_commit i_commit,
    output fpfa_pkg::t_tok    o_tok
);
    import fpfa_pkg::*;

    t_size       r_size, n_size;
    logic        r_taken, n_taken;
    logic [15:0] r_owner, n_owner;
    t_tok        r_tok, n_tok;

    logic hit;
    logic fits;

    always_comb begin
        n_size  = r_size;
        n_taken = r_taken;
        n_owner = r_owner;
        n_tok   = i_tok;
        hit     = int'(i_tok.item.block_index) == int'(i_pos);
        fits    = (int'(i_pos) < int'(i_tok.count)) && !r_taken &&
                  (CMP_W'(r_size) >= CMP_W'(i_tok.item.request_size));

        if (i_tok.valid) begin
            if (i_tok.item.mode == MODE_LOAD) begin
                if (hit) begin
                    n_size          = SIZE_BITS'(i_tok.item.block_size);
                    n_taken         = 1'b0;
                    n_owner         = '0;
                    n_tok.rep_taken = 1'b0;
                    n_tok.rep_owner = '0;
                    n_tok.rep_size  = SIZE_BITS'(i_tok.item.block_size);
                end
            end else if (i_tok.item.mode == MODE_ALLOC) begin
                if (fits) begin
                    if (!i_tok.found) begin
                        n_tok.found     = 1'b1;
                        n_tok.pick      = i_pos;
                        n_tok.pick_size = r_size;
                    end else if ((i_tok.policy == POLICY_BEST && r_size < i_tok.pick_size) ||
                                 (i_tok.policy == POLICY_WORST && r_size > i_tok.pick_size)) begin
                        n_tok.pick      = i_pos;
                        n_tok.pick_size = r_size;
                    end
                end
            end else begin
                if (hit) begin
                    n_tok.rep_taken = r_taken;
                    n_tok.rep_owner = r_taken ? r_owner : 16'd0;
                    n_tok.rep_size  = r_size;
                end
            end
        end

        if (i_commit.valid && i_commit.pick == i_pos) begin
            n_taken = 1'b1;
            n_owner = i_commit.pid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size  <= '0;
            r_taken <= 1'b0;
            r_owner <= '0;
            r_tok   <= '0;
        end else begin
            r_size  <= n_size;
            r_taken <= n_taken;
            r_owner <= n_owner;
            r_tok   <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

FILE: rtl/fpfa_checker.sv
// port level checks of the allocator, bound to the top level
`include "assert_macros.svh"

module fpfa_props (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic                                o_busy,
    input  logic                                o_done,
    input  fpfa_pkg::t_result                   o_result
);
    import fpfa_pkg::*;

    logic grant_beat;

    assign grant_beat = o_done && o_result.status == STATUS_GRANTED;

    // a result beat comes only as a busy period ends; accepted starts set busy and grants report the block taken
    `FPFA_ASSERT_SAME(a_done_idle, i_clk, i_rst_n, o_done, !o_busy && $fell(o_busy))
    `FPFA_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, i_start && !o_busy, o_busy && !o_done)
    `FPFA_ASSERT_NEXT(a_single_beat, i_clk, i_rst_n, o_done, !o_done)
    `FPFA_ASSERT_SAME(a_end_done, i_clk, i_rst_n, $fell(o_busy), o_done)
    `FPFA_ASSERT_SAME(a_grant_taken, i_clk, i_rst_n, grant_beat, o_result.block_taken)

endmodule

bind fixed_partition_fit_allocator fpfa_props u_fpfa_checker (.*);

FILE: dv/fpfa_checker.sv
// checker for the fixed partition allocator: keeps its own partition table, predicts each result beat and compares
module fpfa_checker
    import fpfa_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic                  i_busy,
    input  t_item                 i_item,
    input  logic                  i_done,
    input  t_result               i_result,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    t_size       part_size  [NUM_PARTITIONS];
    logic        part_taken [NUM_PARTITIONS];
    logic [15:0] part_owner [NUM_PARTITIONS];
    logic [1:0]  fit_policy;
    logic [4:0]  blocks_in_use;

    t_result awaited_results[$];
    t_result oldest;
    int      mismatch_count = 0;

    assign o_fail_count = mismatch_count;

    task automatic report_mismatch(input string what, input int unsigned seen,
                                   input int unsigned want);
        $display("%0t ns: mismatch on %s: got %0h, expected %0h", $realtime, what, seen, want);
        mismatch_count++;
    endtask

    function automatic t_result slot_status(input logic [1:0] status, input t_pos pos);
        t_result r;
        r.status        = status;
        r.chosen_block  = 4'(pos);
        r.block_taken   = part_taken[pos];
        r.owner_id      = part_taken[pos] ? part_owner[pos] : 16'h0;
        r.reported_size = 16'(part_size[pos]);
        return r;
    endfunction

    // applies one item to the table and returns the beat it should produce
    function automatic t_result serve_item(input t_item it);
        int      limit;
        logic    found;
        t_pos    pick;
        t_pos    idx;
        t_result r;
        idx   = t_pos'(it.block_index);
        found = 1'b0;
        pick  = '0;
        case (it.mode)
            MODE_LOAD: begin
                part_size[idx]  = t_size'(it.block_size);
                part_taken[idx] = 1'b0;
                part_owner[idx] = 16'h0;
                return slot_status(STATUS_LOADED, idx);
            end
            MODE_ALLOC: begin
                limit = (blocks_in_use > NUM_PARTITIONS) ? NUM_PARTITIONS : int'(blocks_in_use);
                for (int i = 0; i < limit; i++) begin
                    if (part_taken[i] || part_size[i] < t_size'(it.request_size))
                        continue;
                    if (!found) begin
                        found = 1'b1;
                        pick  = t_pos'(i);
                        // first-fit, and the spare policy code, stop at the lowest fit
                        if (fit_policy != POLICY_BEST && fit_policy != POLICY_WORST)
                            break;
                    end else if (fit_policy == POLICY_BEST && part_size[i] < part_size[pick]) begin
                        pick = t_pos'(i);
                    end else if (fit_policy == POLICY_WORST && part_size[i] > part_size[pick]) begin
                        pick = t_pos'(i);
                    end
                end
                if (!found) begin
                    r        = '0;
                    r.status = STATUS_NO_FIT;
                    return r;
                end
                part_taken[pick] = 1'b1;
                part_owner[pick] = it.process_id;
                return slot_status(STATUS_GRANTED, pick);
            end
            default: begin
                return slot_status(STATUS_QUERY, idx);
            end
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_PARTITIONS; i++) begin
                part_size[i]  = '0;
                part_taken[i] = 1'b0;
                part_owner[i] = 16'h0;
            end
            fit_policy    = POLICY_FIRST;
            blocks_in_use = BLOCKS_RESET;
            awaited_results.delete();
        end else begin
            if (i_done) begin
                if (awaited_results.size() == 0) begin
                    report_mismatch("result beat with nothing awaited",
                                    i_result.status, 0);
                end else begin
                    oldest = awaited_results.pop_front();
                    if (i_result.status !== oldest.status)
                        report_mismatch("status", i_result.status, oldest.status);
                    if (i_result.chosen_block !== oldest.chosen_block)
                        report_mismatch("chosen_block", i_result.chosen_block,
                                        oldest.chosen_block);
                    if (i_result.block_taken !== oldest.block_taken)
                        report_mismatch("block_taken", i_result.block_taken,
                                        oldest.block_taken);
                    if (i_result.owner_id !== oldest.owner_id)
                        report_mismatch("owner_id", i_result.owner_id, oldest.owner_id);
                    if (i_result.reported_size !== oldest.reported_size)
                        report_mismatch("reported_size", i_result.reported_size,
                                        oldest.reported_size);
                end
            end
            if (i_start && !i_busy)
                awaited_results.push_back(serve_item(i_item));
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_FIT_POLICY)
                    fit_policy = i_cfg_data[1:0];
                else
                    blocks_in_use = i_cfg_data[4:0];
            end
        end
        o_pending = awaited_results.size();
    end

endmodule

FILE: dv/tb.sv
// testbench top for the fixed partition allocator: clock, reset, stimulus and verdict
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import fpfa_pkg::*;

    localparam logic [1:0] MODE_QUERY   = 2'd2;
    localparam logic [1:0] MODE_SPARE   = 2'd3;
    localparam logic [1:0] POLICY_SPARE = 2'd3;
    localparam int         PHASES       = 8;
    localparam int         PHASE_ITEMS  = 240;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  start    = 1'b0;
    t_item                 item     = '0;
    logic                  cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  busy;
    logic                  done;
    t_result               result;
    int                    fail_count;
    int                    pending;

    int          items_sent = 0;
    int          settings_used = 0;
    int          idle_pct = 0;
    logic [15:0] palette[6];
    logic [1:0]  phase_policy;
    logic [4:0]  phase_blocks;

    fixed_partition_fit_allocator u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_start    (start),
        .i_item     (item),
        .o_busy     (busy),
        .o_done     (done),
        .o_result   (result),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    fpfa_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_item       (item),
        .i_done       (done),
        .i_result     (result),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic t_item make_item(input logic [1:0] mode, input logic [3:0] idx,
                                        input logic [15:0] bsize, input logic [15:0] req,
                                        input logic [15:0] pid);
        t_item it;
        it.mode         = mode;
        it.block_index  = idx;
        it.block_size   = bsize;
        it.request_size = req;
        it.process_id   = pid;
        return it;
    endfunction

    // sizes drawn mostly from a small palette so fits, ties and near misses are common
    function automatic logic [15:0] sized_value(input int exact_pct);
        int          r;
        logic [15:0] p;
        r = $urandom_range(99);
        p = palette[$urandom_range(5)];
        if (r < exact_pct)
            return p;
        if (r < exact_pct + 10)
            return $urandom_range(1) ? p + 16'd1 : p - 16'd1;
        return 16'($urandom_range(65535));
    endfunction

    function automatic t_item random_item();
        int         r;
        logic [1:0] mode;
        r = $urandom_range(99);
        if (r < 35)
            mode = MODE_LOAD;
        else if (r < 80)
            mode = MODE_ALLOC;
        else if (r < 95)
            mode = MODE_QUERY;
        else
            mode = MODE_SPARE;
        return make_item(mode, 4'($urandom_range(15)), sized_value(80), sized_value(65),
                         16'($urandom_range(65535)));
    endfunction

    task automatic drive_beat(input t_item it, input int gap);
        logic [63:0] noise;
        repeat (gap) begin
            @(negedge clk);
            noise = {$urandom, $urandom};
            start = 1'b0;
            item  = t_item'(noise[$bits(t_item)-1:0]);
        end
        @(negedge clk);
        start = 1'b1;
        item  = it;
        do @(posedge clk); while (busy);
        items_sent++;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        start = 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = data;
        @(negedge clk);
        cfg_we   = 1'b0;
        settings_used++;
    endtask

    function automatic int idle_gap();
        int n;
        n = 0;
        while ($urandom_range(99) < idle_pct && n < 40)
            n++;
        return n;
    endfunction

    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    initial begin
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // directed part under reset settings: first-fit, all sixteen partitions
        drive_beat(make_item(MODE_QUERY, 4'd0, 16'h0, 16'h0, 16'h0), 0);
        drive_beat(make_item(MODE_QUERY, 4'd15, 16'hFFFF, 16'hFFFF, 16'hFFFF), 0);
        // zero request fits a free partition of size zero
        drive_beat(make_item(MODE_ALLOC, 4'd0, 16'h0, 16'h0, 16'hFFFF), 0);
        drive_beat(make_item(MODE_LOAD, 4'd0, 16'hFFFF, 16'h0, 16'h0), 0);
        drive_beat(make_item(MODE_LOAD, 4'd15, 16'h0, 16'hFFFF, 16'hFFFF), 0);
        drive_beat(make_item(MODE_LOAD, 4'd5, 16'd100, 16'h0, 16'h0), 0);
        drive_beat(make_item(MODE_LOAD, 4'd6, 16'd100, 16'h0, 16'h0), 0);
        drive_beat(make_item(MODE_LOAD, 4'd7, 16'd50, 16'h0, 16'h0), 0);
        drive_beat(make_item(MODE_ALLOC, 4'd0, 16'h0, 16'hFFFF, 16'h0001), 0);
        drive_beat(make_item(MODE_ALLOC, 4'd0, 16'h0, 16'd60, 16'h1234), 0);
        drive_beat(make_item(MODE_ALLOC, 4'd0, 16'h0, 16'hFFFF, 16'h5555), 0);
        drive_beat(make_item(MODE_SPARE, 4'd5, 16'h0, 16'h0, 16'h0), 0);
        // reload of a taken partition frees it and clears the owner
        drive_beat(make_item(MODE_LOAD, 4'd5, 16'd100, 16'h0, 16'h0), 0);
        drive_beat(make_item(MODE_QUERY, 4'd5, 16'h0, 16'h0, 16'h0), 0);

        wait_drained();
        write_reg(CFG_FIT_POLICY, CFG_DATA_W'(POLICY_BEST));
        drive_beat(make_item(MODE_ALLOC, 4'd0, 16'h0, 16'd40, 16'hAAAA), 0);
        drive_beat(make_item(MODE_LOAD, 4'd7, 16'd50, 16'h0, 16'h0), 0);

        // equal sizes: worst-fit takes the lower index
        wait_drained();
        write_reg(CFG_FIT_POLICY, CFG_DATA_W'(POLICY_WORST));
        drive_beat(make_item(MODE_ALLOC, 4'd0, 16'h0, 16'd40, 16'h0F0F), 0);

        wait_drained();
        write_reg(CFG_FIT_POLICY, CFG_DATA_W'(POLICY_SPARE));
        write_reg(CFG_BLOCKS_IN_USE, 5'd0);
        drive_beat(make_item(MODE_ALLOC, 4'd0, 16'h0, 16'h0, 16'h0002), 0);
        wait_drained();
        write_reg(CFG_BLOCKS_IN_USE, 5'd31);
        drive_beat(make_item(MODE_ALLOC, 4'd0, 16'h0, 16'h0, 16'h0003), 0);
        wait_drained();
        write_reg(CFG_BLOCKS_IN_USE, 5'd1);
        drive_beat(make_item(MODE_ALLOC, 4'd0, 16'h0, 16'h0, 16'h0004), 0);

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin phase_policy = POLICY_FIRST; phase_blocks = 5'd16; end
                1: begin phase_policy = POLICY_BEST;  phase_blocks = 5'd31; end
                2: begin phase_policy = POLICY_WORST; phase_blocks = 5'd1; end
                3: begin phase_policy = POLICY_SPARE; phase_blocks = 5'd0; end
                4: begin phase_policy = POLICY_BEST;  phase_blocks = 5'($urandom_range(2, 15)); end
                5: begin phase_policy = POLICY_WORST; phase_blocks = 5'd16; end
                6: begin phase_policy = POLICY_FIRST; phase_blocks = 5'($urandom_range(17, 31)); end
                default: begin
                    phase_policy = 2'($urandom_range(3));
                    phase_blocks = 5'($urandom_range(31));
                end
            endcase
            palette[0] = 16'h0;
            palette[1] = 16'hFFFF;
            palette[2] = 16'($urandom_range(1, 15));
            palette[3] = 16'($urandom_range(16, 255));
            palette[4] = palette[3];
            palette[5] = 16'($urandom_range(65535));
            idle_pct = (ph % 3 == 0) ? 0 : (ph % 3 == 1) ? 68 : 9;

            wait_drained();
            write_reg(CFG_FIT_POLICY, CFG_DATA_W'(phase_policy));
            write_reg(CFG_BLOCKS_IN_USE, phase_blocks);

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // hold off until the pipe is empty, then restart cold
                if (n == PHASE_ITEMS / 2 && ph % 4 == 1) begin
                    wait_drained();
                    repeat ($urandom_range(8, 40)) @(negedge clk);
                end
                drive_beat(random_item(), idle_gap());
            end
        end

        wait_drained();
        repeat (NUM_PARTITIONS + 4) @(negedge clk);

        $display("run covered %0d items across %0d register writes", items_sent, settings_used);
        $display("policies first, best, worst and the spare code; partitions in use 0 to 31");
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
